>>> hdl/b2t_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2t_pkg
// Shared types, constants and the shift-add-3 step of the binary to TBCD
// encoder.
// ----------------------------------------------------------------------------
package b2t_pkg;

    localparam int BIN_W          = 64;
    localparam int DEC_DIGITS     = 20;              // digits of a 64-bit value
    localparam int MAX_DIGITS     = 15;              // 1..15 kept digits
    localparam int OCT_NIBBLES    = 16;              // nibbles in the octet word
    localparam int COUNT_W        = 4;
    localparam int DIGIT_IDX_W    = $clog2(DEC_DIGITS + 1);
    localparam int BITS_PER_STAGE = 8;
    localparam int DABBLE_STAGES  = BIN_W / BITS_PER_STAGE;

    localparam logic [3:0] FILLER_NIBBLE = 4'hF;

    // binary bits still to shift in, and the BCD accumulator
    typedef struct packed {
        logic [BIN_W-1:0]                 bin;
        logic [DEC_DIGITS-1:0][3:0]       bcd;
    } t_dabble;

    // result of the digit count stage
    typedef struct packed {
        logic [DEC_DIGITS-1:0][3:0]       bcd;
        logic [DIGIT_IDX_W-1:0]           ndig;
        logic [COUNT_W-1:0]               keep;
        logic                             trunc;
    } t_count;

    // result word
    typedef struct packed {
        logic [BIN_W-1:0]                 tbcd_octets;
        logic [COUNT_W-1:0]               digit_count;
        logic                             truncated;
    } t_result;

    // BITS_PER_STAGE shift-add-3 iterations, MSB of bin first
    function automatic t_dabble dabble_steps(input t_dabble d);
        t_dabble r;
        r = d;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            for (int k = 0; k < DEC_DIGITS; k++) begin
                if (r.bcd[k] >= 4'd5) begin
                    r.bcd[k] = r.bcd[k] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/b2t_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2t_in_if
// Input channel: one binary number per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b2t_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] binary_value;

    modport source (output valid, output binary_value, input ready);
    modport sink   (input valid, input binary_value, output ready);
endinterface
`default_nettype wire

>>> hdl/b2t_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2t_out_if
// Output channel: TBCD octets, digit count and truncation flag per word.
// ----------------------------------------------------------------------------
interface b2t_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tbcd_octets;
    logic [3:0]  digit_count;
    logic        truncated;

    modport source (output valid, output tbcd_octets, output digit_count,
                    output truncated, input ready);
    modport sink   (input valid, input tbcd_octets, input digit_count,
                    input truncated, output ready);
endinterface
`default_nettype wire

>>> hdl/binary_to_tbcd_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_tbcd_encoder_unit
// Converts an unsigned 64-bit number into up to 15 TBCD digits, most
// significant digit in the low nibble of octet 0.
// ----------------------------------------------------------------------------
// The unit accepts one number every clock cycle while the output is not
// stalled. Each number passes through the 64 shift-add-3 iterations of the
// binary to BCD conversion, eight per stage over eight stages, then one
// stage that counts the decimal digits and one output stage that packs
// them into octets. Every stage has its own valid bit, so an output stall
// only holds words that cannot move and empty stages upstream keep filling.
// Numbers longer than 15 digits keep their 15 leading digits and raise
// truncated.
module binary_to_tbcd_encoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    b2t_in_if.sink      i_in,
    b2t_out_if.source   o_out
);
    import b2t_pkg::*;

    // conversion chain: index 0 is the input, index DABBLE_STAGES the last stage
    t_dabble s_data  [DABBLE_STAGES+1];
    logic    s_valid [DABBLE_STAGES+1];
    logic    s_ready [DABBLE_STAGES+1];

    assign s_data[0].bin = i_in.binary_value;
    assign s_data[0].bcd = '0;
    assign s_valid[0]    = i_in.valid;
    assign i_in.ready    = s_ready[0];

    for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
        b2t_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    // ---------------- digit count stage ----------------
    logic    r_cnt_valid;
    t_count  r_cnt;
    t_count  n_cnt;
    logic    cnt_ready;
    logic    out_ready;

    assign cnt_ready                = !r_cnt_valid || out_ready;
    assign s_ready[DABBLE_STAGES]   = cnt_ready;

    // highest nonzero digit sets the length; zero is one digit
    always_comb begin
        n_cnt.bcd  = s_data[DABBLE_STAGES].bcd;
        n_cnt.ndig = DIGIT_IDX_W'(1);
        for (int k = 1; k < DEC_DIGITS; k++) begin
            if (s_data[DABBLE_STAGES].bcd[k] != 4'd0) begin
                n_cnt.ndig = DIGIT_IDX_W'(k + 1);
            end
        end
        n_cnt.trunc = (n_cnt.ndig > DIGIT_IDX_W'(MAX_DIGITS));
        n_cnt.keep  = n_cnt.trunc ? COUNT_W'(MAX_DIGITS) : n_cnt.ndig[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= 1'b0;
        end else if (cnt_ready) begin
            r_cnt_valid <= s_valid[DABBLE_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_ready && s_valid[DABBLE_STAGES]) begin
            r_cnt <= n_cnt;
        end
    end

    // ---------------- pack / output stage ----------------
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    assign out_ready = !r_out_valid || o_out.ready;

    // nibble i takes digit ndig-1-i while i < keep, filler after
    always_comb begin
        logic [DIGIT_IDX_W-1:0] idx;
        n_out.tbcd_octets = '1;
        idx               = '0;
        for (int i = 0; i < OCT_NIBBLES; i++) begin
            idx = r_cnt.ndig - DIGIT_IDX_W'(i + 1);
            if (COUNT_W'(i) < r_cnt.keep && i < MAX_DIGITS) begin
                n_out.tbcd_octets[4*i +: 4] = r_cnt.bcd[idx];
            end else begin
                n_out.tbcd_octets[4*i +: 4] = FILLER_NIBBLE;
            end
        end
        n_out.digit_count = r_cnt.keep;
        n_out.truncated   = r_cnt.trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_cnt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_cnt_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tbcd_octets = r_out.tbcd_octets;
    assign o_out.digit_count = r_out.digit_count;
    assign o_out.truncated   = r_out.truncated;

    // ---------------- assertions ----------------
    // count always within the kept range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.digit_count >= COUNT_W'(1) &&
                         o_out.digit_count <= COUNT_W'(MAX_DIGITS)))
        else $error("digit_count out of range");

    // truncation only happens at full length
    a_trunc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.truncated) |-> (o_out.digit_count == COUNT_W'(MAX_DIGITS)))
        else $error("truncated word without full digit count");

    // first nibble is always a decimal digit
    a_first_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.tbcd_octets[3:0] <= 4'd9))
        else $error("first TBCD nibble is not a digit");

    // a counted word moves to the output whenever the output register frees up
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_valid && out_ready) |=> r_out_valid)
        else $error("count stage word lost on advance");

endmodule
`default_nettype wire

>>> hdl/b2t_dabble_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2t_dabble_stage
// One pipeline stage of the binary to BCD conversion: a group of
// shift-add-3 iterations followed by a register with its own valid bit.
// ----------------------------------------------------------------------------
module b2t_dabble_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire b2t_pkg::t_dabble i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output b2t_pkg::t_dabble  o_data
);
    import b2t_pkg::*;

    logic    r_valid;
    t_dabble r_data;
    t_dabble n_data;

    // stage accepts when empty or when its word moves on
    assign o_ready = !r_valid || i_ready;
    assign n_data  = dabble_steps(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> tb/binary_to_tbcd_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_tbcd_encoder_unit_tb
// Self-checking bench for the binary to TBCD encoder. Numbers go in through
// the input channel. Each accepted word is encoded by a local model and
// queued, and every output word is compared field by field against the
// oldest queued encoding. Both handshake sides stall at random in two of three
// pacing phases, none in the third, and the bench drains fully between phases.
// ----------------------------------------------------------------------------
module binary_to_tbcd_encoder_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 265;

    typedef struct {
        logic [63:0]       number;
        b2t_pkg::t_result  enc;
    } t_pending_enc;

    logic i_clk;
    logic i_rst_n;

    b2t_in_if  in_ch ();
    b2t_out_if out_ch ();

    binary_to_tbcd_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [63:0]  number_q [$];    // numbers waiting to be offered
    t_pending_enc encoded_q [$];   // encodings waiting for their output word
    logic         in_taken;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           errors;
    int           n_accepted;
    int           n_truncated;
    int           n_checked;

    // Clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Reference encoding: decimal digits, most significant first, two per octet
    function automatic b2t_pkg::t_result encode_tbcd(input logic [63:0] value);
        b2t_pkg::t_result r;
        logic [63:0]      v;
        logic [3:0]       rev [20];
        int               n;
        int               keep;
        v = value;
        n = 0;
        do begin
            rev[n] = 4'(v % 64'd10);
            v = v / 64'd10;
            n++;
        end while (v != 64'd0 && n < 20);
        keep = (n > b2t_pkg::MAX_DIGITS) ? b2t_pkg::MAX_DIGITS : n;
        r.tbcd_octets = '1;
        for (int i = 0; i < keep; i++) begin
            r.tbcd_octets[4*i +: 4] = rev[n-1-i];
        end
        r.digit_count = 4'(keep);
        r.truncated   = (n > b2t_pkg::MAX_DIGITS);
        return r;
    endfunction

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // Random number: by digit length, raw 64-bit, or close to a power of ten
    function automatic logic [63:0] pick_number();
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] hi;
        int          n;
        int          sel;
        r   = {$urandom, $urandom};
        sel = $urandom_range(9);
        if (sel < 5) begin
            n  = $urandom_range(20, 1);
            lo = (n == 1) ? 64'd0 : pow10(n - 1);
            hi = (n == 20) ? '1 : pow10(n) - 64'd1;
            return lo + r % (hi - lo + 64'd1);
        end else if (sel < 8) begin
            return r;
        end else begin
            return pow10($urandom_range(19)) + 64'($urandom_range(3)) - 64'd2;
        end
    endfunction

    // Driver: offer the next number once the current word has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (number_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid        <= 1'b1;
                in_ch.binary_value <= number_q.pop_front();
            end else begin
                in_ch.valid        <= 1'b0;
                in_ch.binary_value <= {$urandom, $urandom};
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: queue encodings of accepted words, check output words
    always @(posedge i_clk) begin
        t_pending_enc pe;
        in_taken <= in_ch.valid && in_ch.ready && i_rst_n;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pe.number = in_ch.binary_value;
            pe.enc    = encode_tbcd(in_ch.binary_value);
            encoded_q.push_back(pe);
            n_accepted++;
            if (pe.enc.truncated) n_truncated++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (encoded_q.size() == 0) begin
                $display("%0t: output word with nothing expected: octets %h count %0d trunc %0b",
                         $time, out_ch.tbcd_octets, out_ch.digit_count, out_ch.truncated);
                errors++;
            end else begin
                pe = encoded_q.pop_front();
                n_checked++;
                if (out_ch.tbcd_octets !== pe.enc.tbcd_octets) begin
                    $display("%0t: %0d: tbcd_octets expected %h actual %h", $time,
                             pe.number, pe.enc.tbcd_octets, out_ch.tbcd_octets);
                    errors++;
                end
                if (out_ch.digit_count !== pe.enc.digit_count) begin
                    $display("%0t: %0d: digit_count expected %0d actual %0d", $time,
                             pe.number, pe.enc.digit_count, out_ch.digit_count);
                    errors++;
                end
                if (out_ch.truncated !== pe.enc.truncated) begin
                    $display("%0t: %0d: truncated expected %0b actual %0b", $time,
                             pe.number, pe.enc.truncated, out_ch.truncated);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
            @(posedge i_clk);
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("** binary_to_tbcd_encoder_unit: FAILED **");
        $finish;
    end

    // Stimulus sequence
    initial begin
        in_ch.valid        = 1'b0;
        in_ch.binary_value = '0;
        out_ch.ready       = 1'b0;
        in_taken           = 1'b0;
        i_rst_n            = 1'b0;
        errors             = 0;
        n_accepted         = 0;
        n_truncated        = 0;
        n_checked          = 0;
        send_idle_pct      = 15;
        recv_idle_pct      = 82;

        // Directed: zero, digit length edges, truncation edges, all bits
        number_q.push_back(64'd0);
        number_q.push_back(64'd1);
        number_q.push_back(64'd9);
        number_q.push_back(64'd10);
        number_q.push_back(64'd99);
        number_q.push_back(64'd100);
        number_q.push_back(64'd100000000000000);
        number_q.push_back(64'd999999999999999);
        number_q.push_back(64'd1000000000000000);
        number_q.push_back(64'd1000000000000009);
        number_q.push_back(64'd9999999999999999);
        number_q.push_back(64'd5555555555555555);
        number_q.push_back(64'd9999999999999999999);
        number_q.push_back(64'd10000000000000000000);
        number_q.push_back(64'd12345678901234567890);
        number_q.push_back(64'd18446744073709551614);
        number_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        number_q.push_back(64'h8000_0000_0000_0000);
        number_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        number_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        number_q.push_back(64'h5555_5555_5555_5555);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            @(posedge i_clk);
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                number_q.push_back(pick_number());
            end
            // next phase waits until every number is sent and every encoding has come out
            @(negedge i_clk);
            while (number_q.size() > 0 || in_ch.valid || encoded_q.size() > 0) begin
                @(negedge i_clk);
            end
        end

        // let any stray word show up
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (encoded_q.size() != 0) begin
            $display("%0t: %0d encodings never came out", $time, encoded_q.size());
            errors++;
        end

        $display("Encoded %0d numbers (%0d over 15 digits), %0d output words checked,",
                 n_accepted, n_truncated, n_checked);
        $display("under input-heavy, output-heavy and stall-free pacing.");
        if (errors == 0) begin
            $display("** binary_to_tbcd_encoder_unit: PASSED **");
        end else begin
            $display("** binary_to_tbcd_encoder_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/b2t_pkg.sv
hdl/b2t_in_if.sv
hdl/b2t_out_if.sv
hdl/b2t_dabble_stage.sv
hdl/binary_to_tbcd_encoder_unit.sv
tb/binary_to_tbcd_encoder_unit_tb.sv
